// File: rtl/core/mrs_pkg.sv
// ----------------------------------------------------------------------------
// mrs_pkg: shared types, constants and functions
// Holding-register slave definitions: function codes, limits, CRC step.
// ----------------------------------------------------------------------------
package mrs_pkg;

	localparam int REG_DEPTH   = 256;
	localparam int REG_AW      = 8;
	localparam int FRAME_BYTES = 256;
	localparam int MAX_READ    = 125;
	localparam int MIN_FRAME   = 8;

	localparam logic [7:0] FC_READ_HOLD  = 8'h03;
	localparam logic [7:0] FC_WRITE_ONE  = 8'h06;
	localparam logic [7:0] FC_EXC_FLAG   = 8'h80;
	localparam logic [7:0] EXC_ILL_FUNC  = 8'h01;
	localparam logic [7:0] EXC_ILL_ADDR  = 8'h02;
	localparam logic [7:0] EXC_ILL_VALUE = 8'h03;
	localparam logic [7:0] ADDR_BCAST    = 8'h00;

	localparam logic CFG_OWN_ADDR  = 1'b0;
	localparam logic CFG_REGS_USED = 1'b1;

	// register store access, one port
	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [REG_AW-1:0] addr;
		logic [15:0]       wdata;
	} mem_req_t;

	// CRC-16/MODBUS, one byte
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) c = (c >> 1) ^ 16'hA001;
			else c = c >> 1;
		end
		return c;
	endfunction

endpackage

// File: rtl/core/mrs_rx_if.sv
// ----------------------------------------------------------------------------
// mrs_rx_if: received byte channel
// Valid/ready stream of frame bytes with end-of-frame mark.
// ----------------------------------------------------------------------------
interface mrs_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_end;

	modport source (output valid, output rx_byte, output frame_end, input ready);
	modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

// File: rtl/core/mrs_tx_if.sv
// ----------------------------------------------------------------------------
// mrs_tx_if: response word channel
// Valid/ready stream of packed response words.
// ----------------------------------------------------------------------------
interface mrs_tx_if;
	logic        valid;
	logic        ready;
	logic [31:0] tx_word;
	logic [2:0]  tx_bytes;
	logic        tx_last;

	modport source (output valid, output tx_word, output tx_bytes, output tx_last, input ready);
	modport sink (input valid, input tx_word, input tx_bytes, input tx_last, output ready);
endinterface

// File: rtl/core/modbus_rtu_register_slave_core.sv
// ----------------------------------------------------------------------------
// modbus_rtu_register_slave_core: Modbus RTU slave, functions 03 and 06
// Collects frame bytes, checks length, CRC and address, executes the
// request against the holding register store and streams the response.
//
//   channel  dir  handshake      payload
//   rx       in   valid/ready    rx_byte, frame_end
//   tx       out  valid/ready    tx_word, tx_bytes, tx_last
//   cfg      in   cfg_we         cfg_index, cfg_wdata
//
// Bytes are taken only while idle; the closing byte leads into a check state.
// A response is produced as its header bytes (hdr is 3 or 6 bytes), then for
// each register read a request state and the high and low data bytes (the
// RAM read is registered), then the two CRC bytes, packed into words that
// wait in the output register.
// rx is held off while a response is produced; tx stalls stop the producer.
// Reset clears the register store through per-entry valid flags.
// ----------------------------------------------------------------------------
module modbus_rtu_register_slave_core (
	input  logic        clk,
	input  logic        arst_n,
	mrs_rx_if.sink      rx,
	mrs_tx_if.source    tx,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_wdata
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_CHECK  = 8'b0000_0010,
		S_HDR    = 8'b0000_0100,
		S_RREQ   = 8'b0000_1000,
		S_RHI    = 8'b0001_0000,
		S_RLO    = 8'b0010_0000,
		S_CRC_LO = 8'b0100_0000,
		S_CRC_HI = 8'b1000_0000
	} state_t;

	state_t state_q;

	// configuration
	logic [7:0] own_addr_q;
	logic [8:0] regs_used_q;

	// frame collection
	logic [7:0]  hdr_q [6];
	logic [8:0]  cnt_q;
	logic [15:0] crc_q;
	logic [7:0]  tail_q [2];

	// response
	logic [7:0]  msg_q [6];
	logic [2:0]  msg_len_q;
	logic [2:0]  idx_q;
	logic        rd_ok_q;
	logic [7:0]  rd_addr_q;
	logic [6:0]  rd_left_q;
	logic [15:0] tcrc_q;
	logic [31:0] acc_q;
	logic [1:0]  acc_n_q;

	// output register
	logic        tx_valid_q;
	logic [31:0] tx_word_q;
	logic [2:0]  tx_bytes_q;
	logic        tx_last_q;

	mrs_pkg::mem_req_t mreq;
	logic [15:0]       rd_data;

	// frame decode
	logic [15:0] f_a, f_v;
	logic [8:0]  total;
	logic        frame_ok;
	assign f_a      = {hdr_q[2], hdr_q[3]};
	assign f_v      = {hdr_q[4], hdr_q[5]};
	assign total    = regs_used_q[8] ? 9'(mrs_pkg::REG_DEPTH) : regs_used_q;
	assign frame_ok = (cnt_q >= 9'(mrs_pkg::MIN_FRAME))
		&& ({tail_q[1], tail_q[0]} == crc_q)
		&& (hdr_q[0] == own_addr_q || hdr_q[0] == mrs_pkg::ADDR_BCAST);

	logic rx_fire;
	assign rx.ready = (state_q == S_IDLE);
	assign rx_fire  = rx.valid && rx.ready;

	// byte producer
	logic       emit_v, emit_last, can_emit, emit_fire;
	logic [7:0] emit_b;
	assign can_emit = !tx_valid_q || tx.ready;

	always_comb begin
		emit_v    = 1'b0;
		emit_b    = 8'h00;
		emit_last = 1'b0;
		unique case (state_q)
			S_HDR:    begin emit_v = 1'b1; emit_b = msg_q[idx_q]; end
			S_RHI:    begin emit_v = 1'b1; emit_b = rd_data[15:8]; end
			S_RLO:    begin emit_v = 1'b1; emit_b = rd_data[7:0]; end
			S_CRC_LO: begin emit_v = 1'b1; emit_b = tcrc_q[7:0]; end
			S_CRC_HI: begin emit_v = 1'b1; emit_b = tcrc_q[15:8]; emit_last = 1'b1; end
			default:  begin emit_v = 1'b0; end
		endcase
	end
	assign emit_fire = emit_v && can_emit;

	// word packing
	logic [31:0] acc_next;
	logic [2:0]  n_next;
	logic        word_done;
	assign acc_next  = acc_q | ({24'h0, emit_b} << (5'd24 - {acc_n_q, 3'b000}));
	assign n_next    = {1'b0, acc_n_q} + 3'd1;
	assign word_done = emit_fire && (n_next == 3'd4 || emit_last);

	// register store port
	always_comb begin
		mreq       = '0;
		mreq.addr  = rd_addr_q;
		mreq.wdata = f_v;
		if (state_q == S_CHECK && frame_ok && hdr_q[1] == mrs_pkg::FC_WRITE_ONE
			&& {1'b0, f_a} < {8'h00, total}) begin
			mreq.wr_en = 1'b1;
			mreq.addr  = f_a[7:0];
		end else if (state_q == S_RREQ) begin
			mreq.rd_en = 1'b1;
		end
	end

	mrs_regmem u_regmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mreq),
		.rd_data (rd_data)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q  <= 8'd1;
			regs_used_q <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mrs_pkg::CFG_OWN_ADDR:  own_addr_q  <= cfg_wdata[7:0];
				mrs_pkg::CFG_REGS_USED: regs_used_q <= cfg_wdata;
			endcase
		end
	end

	// sequencer and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			crc_q      <= 16'hFFFF;
			tail_q[0]  <= '0;
			tail_q[1]  <= '0;
			for (int i = 0; i < 6; i++) hdr_q[i] <= '0;
			acc_n_q    <= '0;
			acc_q      <= '0;
			tx_valid_q <= 1'b0;
		end else begin
			// output register
			if (word_done) begin
				tx_valid_q <= 1'b1;
				tx_word_q  <= acc_next;
				tx_bytes_q <= n_next;
				tx_last_q  <= emit_last;
			end else if (tx.ready) begin
				tx_valid_q <= 1'b0;
			end
			if (emit_fire) begin
				// CRC covers the message bytes only, not its own two bytes
				if (state_q != S_CRC_LO && state_q != S_CRC_HI)
					tcrc_q <= mrs_pkg::crc_step(tcrc_q, emit_b);
				acc_q   <= word_done ? 32'h0 : acc_next;
				acc_n_q <= word_done ? 2'd0 : n_next[1:0];
			end

			unique case (state_q)
				S_IDLE: begin
					if (rx_fire) begin
						if (cnt_q < 9'(mrs_pkg::FRAME_BYTES)) begin
							if (cnt_q >= 9'd2) crc_q <= mrs_pkg::crc_step(crc_q, tail_q[0]);
							tail_q[0] <= tail_q[1];
							tail_q[1] <= rx.rx_byte;
							if (cnt_q < 9'd6) hdr_q[cnt_q[2:0]] <= rx.rx_byte;
							cnt_q <= cnt_q + 9'd1;
						end
						if (rx.frame_end) state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					// decide response, then drop the frame state
					msg_q[0] <= hdr_q[0];
					msg_q[1] <= hdr_q[1] | mrs_pkg::FC_EXC_FLAG;
					msg_q[2] <= mrs_pkg::EXC_ILL_FUNC;
					msg_len_q <= 3'd3;
					rd_ok_q   <= 1'b0;
					rd_addr_q <= f_a[7:0];
					rd_left_q <= f_v[6:0];
					idx_q     <= '0;
					tcrc_q    <= 16'hFFFF;
					if (hdr_q[1] == mrs_pkg::FC_READ_HOLD) begin
						if (f_v > 16'(mrs_pkg::MAX_READ)) begin
							msg_q[2] <= mrs_pkg::EXC_ILL_VALUE;
						end else if ({1'b0, f_a} + {1'b0, f_v} > {8'h00, total}) begin
							msg_q[2] <= mrs_pkg::EXC_ILL_ADDR;
						end else begin
							msg_q[1] <= mrs_pkg::FC_READ_HOLD;
							msg_q[2] <= {f_v[6:0], 1'b0};
							rd_ok_q  <= 1'b1;
						end
					end else if (hdr_q[1] == mrs_pkg::FC_WRITE_ONE) begin
						if ({1'b0, f_a} >= {8'h00, total}) begin
							msg_q[2] <= mrs_pkg::EXC_ILL_ADDR;
						end else begin
							for (int i = 1; i < 6; i++) msg_q[i] <= hdr_q[i];
							msg_len_q <= 3'd6;
						end
					end
					if (frame_ok && hdr_q[0] != mrs_pkg::ADDR_BCAST) state_q <= S_HDR;
					else state_q <= S_IDLE;
					cnt_q     <= '0;
					crc_q     <= 16'hFFFF;
					tail_q[0] <= '0;
					tail_q[1] <= '0;
					for (int i = 0; i < 6; i++) hdr_q[i] <= '0;
				end
				S_HDR: begin
					if (emit_fire) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q + 3'd1 == msg_len_q) begin
							if (rd_ok_q && rd_left_q != '0) state_q <= S_RREQ;
							else state_q <= S_CRC_LO;
						end
					end
				end
				S_RREQ: state_q <= S_RHI;
				S_RHI: if (emit_fire) state_q <= S_RLO;
				S_RLO: begin
					if (emit_fire) begin
						rd_addr_q <= rd_addr_q + 8'd1;
						rd_left_q <= rd_left_q - 7'd1;
						state_q   <= (rd_left_q == 7'd1) ? S_CRC_LO : S_RREQ;
					end
				end
				S_CRC_LO: if (emit_fire) state_q <= S_CRC_HI;
				S_CRC_HI: if (emit_fire) state_q <= S_IDLE;
			endcase
		end
	end

	assign tx.valid    = tx_valid_q;
	assign tx.tx_word  = tx_word_q;
	assign tx.tx_bytes = tx_bytes_q;
	assign tx.tx_last  = tx_last_q;

`ifndef SYNTHESIS
	// the single RAM port never reads and writes at once
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mreq.wr_en && mreq.rd_en)) else $error("regmem read and write collide");

	// a new word is only loaded when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_valid_q && !tx.ready) |=> tx_valid_q && $stable(tx_word_q))
		else $error("pending response word overwritten");

	// response ends on a final word with lanes empty
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(word_done && emit_last) |=> acc_n_q == 2'd0 && state_q == S_IDLE)
		else $error("packer not flushed at end of response");
`endif

endmodule

// File: rtl/core/mrs_regmem.sv
// ----------------------------------------------------------------------------
// mrs_regmem: holding register store
// Single-port synchronous RAM with a registered read, valid bits give zero reset.
// ----------------------------------------------------------------------------
module mrs_regmem (
	input  logic               clk,
	input  logic               arst_n,
	input  mrs_pkg::mem_req_t  req,
	output logic [15:0]        rd_data
);

	logic [15:0]                  mem [mrs_pkg::REG_DEPTH];
	logic [mrs_pkg::REG_DEPTH-1:0] vld_q;
	logic [15:0]                  rd_data_q;
	logic                         rd_vld_q;

	// storage array
	always_ff @(posedge clk) begin
		if (req.wr_en) mem[req.addr] <= req.wdata;
		if (req.rd_en) rd_data_q <= mem[req.addr];
	end

	// per-entry written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) vld_q[req.addr] <= 1'b1;
			if (req.rd_en) rd_vld_q <= vld_q[req.addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : 16'h0000;

endmodule

// File: dv/mrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_checker: response predictor and scoreboard
// Watches the rx and tx channels, rebuilds each frame, predicts the packed
// response words and compares them with what the slave sends.
// ----------------------------------------------------------------------------
module mrs_checker
	import mrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	mrs_rx_if           rx,
	mrs_tx_if           tx,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_wdata,
	output int          fail_count,
	output int          pending_words,
	output int          resp_words_seen
);

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
	} tx_beat_t;

	logic [15:0] shadow_regs [REG_DEPTH];
	logic [7:0]  hdr [6];
	logic [7:0]  tail [2];
	int          kept;
	logic [15:0] crc_acc;
	logic [7:0]  station;
	int          regs_limit;
	tx_beat_t    expected_words [$];

	// bitwise CRC-16/MODBUS, one byte
	function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
		c = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		return c;
	endfunction

	// append CRC to a response and queue it as packed words
	task automatic queue_response(input logic [7:0] msg [], input int len);
		logic [15:0] c;
		logic [7:0]  full [];
		tx_beat_t    beat;
		c = 16'hFFFF;
		for (int i = 0; i < len; i++) c = crc16_byte(c, msg[i]);
		full = new[len + 2];
		for (int i = 0; i < len; i++) full[i] = msg[i];
		full[len] = c[7:0];
		full[len + 1] = c[15:8];
		len += 2;
		for (int i = 0; i < len; i += 4) begin
			beat = '0;
			for (int j = 0; j < 4; j++) begin
				beat.word = beat.word << 8;
				if (i + j < len) begin
					beat.word[7:0] = full[i + j];
					beat.nbytes++;
				end
			end
			beat.last = (i + 4 >= len);
			expected_words.push_back(beat);
		end
	endtask

	// execute a closed frame against the shadow store
	task automatic execute_frame();
		logic [7:0] msg [];
		int          len, total, start, qty;
		msg = new[264];
		if (kept < MIN_FRAME) return;
		if ({tail[1], tail[0]} != crc_acc) return;
		if (hdr[0] != station && hdr[0] != ADDR_BCAST) return;
		total = (regs_limit < REG_DEPTH) ? regs_limit : REG_DEPTH;
		start = {hdr[2], hdr[3]};
		qty = {hdr[4], hdr[5]};
		msg[0] = hdr[0];
		if (hdr[1] == FC_READ_HOLD) begin
			if (qty > MAX_READ) begin
				msg[1] = FC_READ_HOLD | FC_EXC_FLAG; msg[2] = EXC_ILL_VALUE; len = 3;
			end else if (start + qty > total) begin
				msg[1] = FC_READ_HOLD | FC_EXC_FLAG; msg[2] = EXC_ILL_ADDR; len = 3;
			end else begin
				msg[1] = FC_READ_HOLD;
				msg[2] = 8'(qty * 2);
				len = 3;
				for (int i = 0; i < qty; i++) begin
					msg[len++] = shadow_regs[start + i][15:8];
					msg[len++] = shadow_regs[start + i][7:0];
				end
			end
		end else if (hdr[1] == FC_WRITE_ONE) begin
			if (start >= total) begin
				msg[1] = FC_WRITE_ONE | FC_EXC_FLAG; msg[2] = EXC_ILL_ADDR; len = 3;
			end else begin
				shadow_regs[start] = 16'(qty);
				for (int i = 1; i < 6; i++) msg[i] = hdr[i];
				len = 6;
			end
		end else begin
			msg[1] = hdr[1] | FC_EXC_FLAG; msg[2] = EXC_ILL_FUNC; len = 3;
		end
		if (hdr[0] != ADDR_BCAST) queue_response(msg, len);
	endtask

	task automatic clear_frame_state();
		foreach (hdr[i]) hdr[i] = '0;
		tail[0] = '0;
		tail[1] = '0;
		kept = 0;
		crc_acc = 16'hFFFF;
	endtask

	// sample both channels at each edge
	always @(posedge clk or negedge arst_n) begin
		tx_beat_t exp_beat;
		if (!arst_n) begin
			foreach (shadow_regs[i]) shadow_regs[i] = '0;
			clear_frame_state();
			station = 8'd1;
			regs_limit = 256;
			expected_words.delete();
			fail_count = 0;
			resp_words_seen = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_OWN_ADDR) station = cfg_wdata[7:0];
				else regs_limit = cfg_wdata;
			end
			if (tx.valid && tx.ready) begin
				resp_words_seen++;
				if (expected_words.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("ERROR: unexpected word %h bytes=%0d last=%0b",
							tx.tx_word, tx.tx_bytes, tx.tx_last);
				end else begin
					exp_beat = expected_words.pop_front();
					if (tx.tx_word !== exp_beat.word || tx.tx_bytes !== exp_beat.nbytes ||
						tx.tx_last !== exp_beat.last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("ERROR: word exp %h/%0d/%0b got %h/%0d/%0b",
								exp_beat.word, exp_beat.nbytes, exp_beat.last,
								tx.tx_word, tx.tx_bytes, tx.tx_last);
					end
				end
			end
			if (rx.valid && rx.ready) begin
				if (kept < FRAME_BYTES) begin
					if (kept >= 2) crc_acc = crc16_byte(crc_acc, tail[0]);
					tail[0] = tail[1];
					tail[1] = rx.rx_byte;
					if (kept < 6) hdr[kept] = rx.rx_byte;
					kept++;
				end
				if (rx.frame_end) begin
					execute_frame();
					clear_frame_state();
				end
			end
		end
	end

	assign pending_words = expected_words.size();

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: Modbus register slave stimulus and verdict
// Sends directed and random frames (reads, writes, exceptions, bad CRC,
// short, broadcast, foreign address) under several idle and stall
// patterns and configurations; the checker scores the responses.
// ----------------------------------------------------------------------------
module testbench;
	import mrs_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [8:0] cfg_wdata;
	int         fail_count, pending_words, resp_words_seen;
	int         src_idle_pct, sink_stall_pct;
	int         frames_sent, bytes_sent;
	bit         hold_off;
	longint     cycle_cnt;
	logic [7:0] station;
	int         regs_limit;

	mrs_rx_if rx_ch ();
	mrs_tx_if tx_ch ();

	modbus_rtu_register_slave_core u_dut (
		.clk(clk), .arst_n(arst_n), .rx(rx_ch.sink), .tx(tx_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	mrs_checker u_checker (
		.clk(clk), .arst_n(arst_n), .rx(rx_ch), .tx(tx_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending_words(pending_words),
		.resp_words_seen(resp_words_seen)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > 2000000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver with random stalls and an optional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) tx_ch.ready <= 1'b0;
		else tx_ch.ready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
	end

	// one transaction on rx, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		rx_ch.frame_end <= last;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		bytes_sent++;
	endtask

	// send a frame; bad_crc 0 good, 1 corrupted
	task automatic send_frame(input logic [7:0] body [$], input bit bad_crc);
		logic [15:0] c;
		c = 16'hFFFF;
		foreach (body[i]) c = crc_step(c, body[i]);
		if (bad_crc) c ^= 16'(1 << $urandom_range(15));
		body.push_back(c[7:0]);
		body.push_back(c[15:8]);
		foreach (body[i]) send_byte(body[i], i == body.size() - 1);
		rx_ch.valid <= 1'b0;
		frames_sent++;
	endtask

	task automatic send_req(input logic [7:0] addr, input logic [7:0] func,
		input logic [15:0] a, input logic [15:0] v, input bit bad_crc);
		logic [7:0] body [$];
		body = {addr, func, a[15:8], a[7:0], v[15:8], v[7:0]};
		send_frame(body, bad_crc);
	endtask

	// raw bytes, no CRC appended (short and junk frames)
	task automatic send_raw(input int len);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom), i == len - 1);
		rx_ch.valid <= 1'b0;
		frames_sent++;
	endtask

	// write one register while idle
	task automatic write_cfg(input logic idx, input logic [8:0] val);
		wait_drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_OWN_ADDR) station = val[7:0];
		else regs_limit = val;
	endtask

	task automatic wait_drain();
		int guard;
		guard = 0;
		while (pending_words != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (500) @(posedge clk);
	endtask

	// random request, mostly well-formed, aimed mostly at this station
	task automatic random_req();
		int r, lim;
		logic [7:0] addr;
		logic [15:0] a, v;
		r = $urandom_range(99);
		lim = (regs_limit < 256) ? regs_limit : 256;
		addr = ($urandom_range(9) == 0) ? ADDR_BCAST :
			($urandom_range(9) == 0) ? 8'($urandom) : station;
		if (r < 40) begin
			v = ($urandom_range(9) == 0) ? 16'($urandom_range(150)) : 16'($urandom_range(8));
			a = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(lim));
			send_req(addr, FC_READ_HOLD, a, v, $urandom_range(19) == 0);
		end else if (r < 80) begin
			a = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(lim));
			send_req(addr, FC_WRITE_ONE, a, 16'($urandom), $urandom_range(19) == 0);
		end else if (r < 88) begin
			send_req(addr, 8'($urandom), 16'($urandom), 16'($urandom), 1'b0);
		end else if (r < 95) begin
			send_raw($urandom_range(1, 7));
		end else begin
			send_raw($urandom_range(8, 12));
		end
	endtask

	task automatic random_phase(input int idle, input int stall, input int n);
		src_idle_pct = idle;
		sink_stall_pct = stall;
		repeat (n) random_req();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_OWN_ADDR;
		cfg_wdata = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		rx_ch.frame_end = 1'b0;
		hold_off = 1'b0;
		cycle_cnt = 0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		frames_sent = 0;
		bytes_sent = 0;
		station = 8'd1;
		regs_limit = 256;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (300) @(posedge clk);

		// directed: reads, writes, exceptions, broadcast, drops
		send_req(8'd1, FC_READ_HOLD, 16'd0, 16'd0, 1'b0);
		send_req(8'd1, FC_WRITE_ONE, 16'd0, 16'hFFFF, 1'b0);
		send_req(8'd0, FC_WRITE_ONE, 16'd7, 16'h1234, 1'b0);
		send_req(8'd1, FC_READ_HOLD, 16'd0, 16'd8, 1'b0);
		send_req(8'd1, FC_READ_HOLD, 16'd131, 16'd125, 1'b0);
		send_req(8'd1, FC_READ_HOLD, 16'd0, 16'd126, 1'b0);
		send_req(8'd1, FC_READ_HOLD, 16'd200, 16'd57, 1'b0);
		send_req(8'd1, FC_WRITE_ONE, 16'd256, 16'd1, 1'b0);
		send_req(8'd1, 8'hFF, 16'd0, 16'd0, 1'b0);
		send_req(8'd1, FC_READ_HOLD, 16'd0, 16'd1, 1'b1);
		send_req(8'd2, FC_READ_HOLD, 16'd0, 16'd1, 1'b0);
		send_raw(7);
		send_raw(1);

		// configuration extremes
		write_cfg(CFG_OWN_ADDR, 9'd255);
		write_cfg(CFG_REGS_USED, 9'd0);
		send_req(8'd255, FC_READ_HOLD, 16'd0, 16'd1, 1'b0);
		send_req(8'd255, FC_WRITE_ONE, 16'd0, 16'd1, 1'b0);
		write_cfg(CFG_REGS_USED, 9'd511);

		write_cfg(CFG_OWN_ADDR, 9'd0);
		write_cfg(CFG_REGS_USED, 9'd16);
		random_phase(64, 0, 2);

		write_cfg(CFG_OWN_ADDR, 9'd17);
		write_cfg(CFG_REGS_USED, 9'd256);
		random_phase(0, 64, 2);

		// receiver holds off while requests keep coming
		fork
			begin
				hold_off = 1'b1;
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
			repeat (2) send_req(station, FC_READ_HOLD, 16'd0, 16'd10, 1'b0);
		join

		write_cfg(CFG_OWN_ADDR, 9'd1);
		write_cfg(CFG_REGS_USED, 9'd100);
		random_phase(34, 34, 3);
		wait_drain();

		$display("Sent %0d frames (%0d bytes), checked %0d response words.",
			frames_sent, bytes_sent, resp_words_seen);
		$display("Covered reads, writes, all exception codes, drops and config extremes.");
		if (fail_count == 0 && pending_words == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/mrs_pkg.sv
rtl/core/mrs_rx_if.sv
rtl/core/mrs_tx_if.sv
rtl/core/mrs_regmem.sv
rtl/core/modbus_rtu_register_slave_core.sv
dv/mrs_checker.sv
dv/testbench.sv
